// File: src/pzi_pkg.sv
// ----------------------------------------------------------------------------
// pzi_pkg
// Shared types, codes and saturation helpers for the pan/zoom camera block.
// ----------------------------------------------------------------------------
package pzi_pkg;

    localparam int CfgW    = 24;
    localparam int CfgAddrW = 3;
    localparam int InDataW  = 136;
    localparam int OutDataW = 88;
    localparam int DivBits  = 46;

    localparam logic [CfgAddrW-1:0] REG_MIN_SCALE  = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_MAX_SCALE  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_SCALE_FRIC = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_DRAG_FRIC  = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_WIN_W      = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_WIN_H      = 3'd5;

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_IMPULSE  = 2'd1;
    localparam logic [1:0] ACT_VELOCITY = 2'd2;

    localparam logic signed [23:0] ZoomRunLimit = 24'sd32768;
    localparam logic [63:0]        SpeedSqLimit = 64'd225 << 32;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_Z1, S_Z2, S_Z3, S_ZD1, S_ZD2, S_ZD3, S_ZD4, S_Z4,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        M_NONE, M_RATE_DT, M_DT_SFR, M_RATE_K, M_AX2, M_AY2,
        M_VX_DT, M_VY_DT, M_DT_DFR, M_VX_K, M_VY_K
    } mul_op_t;

    typedef enum logic [3:0] {
        U_NONE, U_SNEW, U_K, U_QOLD, U_POSX_Z, U_POSY_Z, U_RATE,
        U_SQ, U_POSX_P, U_POSY_P, U_VELX, U_VELY
    } upd_op_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul;
        upd_op_t upd;
        logic    div_start;
        logic    div_y;
        logic    div_new;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic zoom_go;
        logic pan_go;
        logic div_done;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        if (x > 48'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -48'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
        if (x > 48'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (x < -48'sd8388608) begin
            return 24'sh800000;
        end
        return x[23:0];
    endfunction

endpackage

// File: src/pzi_div.sv
// ----------------------------------------------------------------------------
// pzi_div
// Restoring divider, one quotient bit per cycle: trunc(d * 2^31 / s).
// ----------------------------------------------------------------------------
module pzi_div
    import pzi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] d,
    input  logic [23:0]        s,
    output logic               done,
    output logic signed [46:0] q
);

    logic [DivBits-1:0] num_reg, num_next;
    logic [24:0]        rem_reg, rem_next;
    logic [23:0]        div_reg, div_next;
    logic               neg_reg, neg_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [15:0]        mag;
    logic [24:0]        sh;

    always_comb begin
        mag       = d[15] ? 16'(-d) : 16'(d);
        sh        = {rem_reg[23:0], num_reg[DivBits-1]};
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = {mag[14:0], 31'd0};
            rem_next  = '0;
            div_next  = s;
            neg_next  = d[15];
            cnt_next  = 6'(DivBits);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, div_reg}) begin
                rem_next = sh - {1'b0, div_reg};
                num_next = {num_reg[DivBits-2:0], 1'b1};
            end else begin
                rem_next = sh;
                num_next = {num_reg[DivBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

endmodule

// File: src/pzi_ctrl.sv
// ----------------------------------------------------------------------------
// pzi_ctrl
// Sequencer: steps the shared multiplier and divider through one tick.
// ----------------------------------------------------------------------------
module pzi_ctrl
    import pzi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_DECODE;
            S_DECODE: begin
                if (!status.is_tick) state_next = S_OUT;
                else if (status.zoom_go) state_next = S_Z1;
                else state_next = S_P1;
            end
            S_Z1:  state_next = S_Z2;
            S_Z2:  state_next = S_Z3;
            S_Z3:  state_next = S_ZD1;
            S_ZD1: if (status.div_done) state_next = S_ZD2;
            S_ZD2: if (status.div_done) state_next = S_ZD3;
            S_ZD3: if (status.div_done) state_next = S_ZD4;
            S_ZD4: if (status.div_done) state_next = S_Z4;
            S_Z4:  state_next = S_P1;
            S_P1:  state_next = S_P2;
            S_P2:  state_next = S_P3;
            S_P3:  state_next = status.pan_go ? S_P4 : S_OUT;
            S_P4:  state_next = S_P5;
            S_P5:  state_next = S_P6;
            S_P6:  state_next = S_P7;
            S_P7:  state_next = S_P8;
            S_P8:  state_next = S_P9;
            S_P9:  state_next = S_OUT;
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul     = M_NONE;
        cmd.upd     = U_NONE;
        s_tready    = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_Z1: cmd.mul = M_RATE_DT;
            S_Z2: begin
                cmd.upd = U_SNEW;
                cmd.mul = M_DT_SFR;
            end
            S_Z3: begin
                cmd.upd       = U_K;
                cmd.div_start = 1'b1;
            end
            S_ZD1: if (status.div_done) begin
                cmd.upd       = U_QOLD;
                cmd.div_start = 1'b1;
                cmd.div_new   = 1'b1;
            end
            S_ZD2: if (status.div_done) begin
                cmd.upd       = U_POSX_Z;
                cmd.div_start = 1'b1;
                cmd.div_y     = 1'b1;
            end
            S_ZD3: if (status.div_done) begin
                cmd.upd       = U_QOLD;
                cmd.div_start = 1'b1;
                cmd.div_y     = 1'b1;
                cmd.div_new   = 1'b1;
            end
            S_ZD4: if (status.div_done) begin
                cmd.upd = U_POSY_Z;
                cmd.mul = M_RATE_K;
            end
            S_Z4: cmd.upd = U_RATE;
            S_P1: cmd.mul = M_AX2;
            S_P2: begin
                cmd.upd = U_SQ;
                cmd.mul = M_AY2;
            end
            S_P4: cmd.mul = M_DT_DFR;
            S_P5: begin
                cmd.upd = U_K;
                cmd.mul = M_VX_DT;
            end
            S_P6: begin
                cmd.upd = U_POSX_P;
                cmd.mul = M_VY_DT;
            end
            S_P7: begin
                cmd.upd = U_POSY_P;
                cmd.mul = M_VX_K;
            end
            S_P8: begin
                cmd.upd = U_VELX;
                cmd.mul = M_VY_K;
            end
            S_P9: cmd.upd = U_VELY;
            S_OUT: if (out_free) begin
                cmd.out_load = 1'b1;
                mvalid_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

// File: src/pzi_dp.sv
// ----------------------------------------------------------------------------
// pzi_dp
// Camera state, configuration, shared 33x33 multiplier and the divider.
// ----------------------------------------------------------------------------
module pzi_dp
    import pzi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_wdata,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic [1:0]          s_tuser,
    input  cmd_t                cmd,
    output status_t             status,
    output logic [OutDataW-1:0] m_tdata
);

    logic [23:0]        min_reg, max_reg, sfr_reg, dfr_reg;
    logic [12:0]        win_w_reg, win_h_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [23:0]        scale_reg;
    logic signed [23:0] rate_reg;
    logic [12:0]        piv_x_reg, piv_y_reg;
    logic [1:0]         act_reg;
    logic [15:0]        dt_reg;
    logic               drag_reg;
    logic signed [65:0] prod_reg;
    logic [23:0]        snew_reg, k_reg;
    logic signed [46:0] qold_reg;
    logic [62:0]        sq_reg;
    logic [OutDataW-1:0] out_reg;

    logic signed [32:0] mul_a, mul_b, ax, ay;
    logic signed [47:0] f16, s_sum, c1, c2;
    logic signed [15:0] d_x, d_y;
    logic [63:0]        sq_sum;
    logic               div_done;
    logic signed [46:0] div_q;
    logic signed [23:0] imp;

    assign imp = $signed(s_tdata[40:17]);
    assign f16 = prod_reg[63:16];
    assign ax  = vel_x_reg[31] ? -33'(vel_x_reg) : 33'(vel_x_reg);
    assign ay  = vel_y_reg[31] ? -33'(vel_y_reg) : 33'(vel_y_reg);
    assign d_x = $signed({2'b0, piv_x_reg, 1'b0}) - $signed({3'b0, win_w_reg});
    assign d_y = $signed({2'b0, piv_y_reg, 1'b0}) - $signed({3'b0, win_h_reg});
    assign sq_sum = {1'b0, sq_reg} + 64'(prod_reg[63:0]);

    always_comb begin
        s_sum = $signed({24'd0, scale_reg}) + f16;
        c1 = (s_sum < $signed({24'd0, min_reg})) ? $signed({24'd0, min_reg}) : s_sum;
        c2 = (c1 > $signed({24'd0, max_reg})) ? $signed({24'd0, max_reg}) : c1;
        if (c2 < 48'sd1) c2 = 48'sd1;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            M_RATE_DT: begin mul_a = 33'(rate_reg); mul_b = $signed({17'd0, dt_reg}); end
            M_DT_SFR:  begin mul_a = $signed({17'd0, dt_reg}); mul_b = $signed({9'd0, sfr_reg}); end
            M_RATE_K:  begin mul_a = 33'(rate_reg); mul_b = $signed({9'd0, k_reg}); end
            M_AX2:     begin mul_a = ax; mul_b = ax; end
            M_AY2:     begin mul_a = ay; mul_b = ay; end
            M_VX_DT:   begin mul_a = 33'(vel_x_reg); mul_b = $signed({17'd0, dt_reg}); end
            M_VY_DT:   begin mul_a = 33'(vel_y_reg); mul_b = $signed({17'd0, dt_reg}); end
            M_DT_DFR:  begin mul_a = $signed({17'd0, dt_reg}); mul_b = $signed({9'd0, dfr_reg}); end
            M_VX_K:    begin mul_a = 33'(vel_x_reg); mul_b = $signed({9'd0, k_reg}); end
            M_VY_K:    begin mul_a = 33'(vel_y_reg); mul_b = $signed({9'd0, k_reg}); end
            default:   ;
        endcase
    end

    pzi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .d       (cmd.div_y ? d_y : d_x),
        .s       (cmd.div_new ? snew_reg : scale_reg),
        .done    (div_done),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load) begin
            act_reg  <= s_tuser;
            dt_reg   <= s_tdata[15:0];
            drag_reg <= s_tdata[16];
        end
        case (cmd.upd)
            U_SNEW: snew_reg <= c2[23:0];
            U_K:    k_reg    <= prod_reg[39:16];
            U_QOLD: qold_reg <= div_q;
            U_SQ:   sq_reg   <= prod_reg[62:0];
            default: ;
        endcase
        if (cmd.out_load) begin
            out_reg <= {scale_reg, pos_y_reg, pos_x_reg};
        end
        if (!aresetn) begin
            min_reg   <= 24'd6554;
            max_reg   <= 24'd655360;
            sfr_reg   <= 24'd262144;
            dfr_reg   <= 24'd393216;
            win_w_reg <= 13'd1920;
            win_h_reg <= 13'd1080;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            scale_reg <= 24'd65536;
            rate_reg  <= '0;
            piv_x_reg <= '0;
            piv_y_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MIN_SCALE:  min_reg   <= cfg_wdata;
                    REG_MAX_SCALE:  max_reg   <= cfg_wdata;
                    REG_SCALE_FRIC: sfr_reg   <= cfg_wdata;
                    REG_DRAG_FRIC:  dfr_reg   <= cfg_wdata;
                    REG_WIN_W:      win_w_reg <= cfg_wdata[12:0];
                    REG_WIN_H:      win_h_reg <= cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (cmd.load && s_tuser == ACT_IMPULSE) begin
                rate_reg  <= sat24(48'(rate_reg) + 48'(imp));
                piv_x_reg <= s_tdata[53:41];
                piv_y_reg <= s_tdata[66:54];
            end
            if (cmd.load && s_tuser == ACT_VELOCITY) begin
                vel_x_reg <= $signed(s_tdata[98:67]);
                vel_y_reg <= $signed(s_tdata[130:99]);
            end
            case (cmd.upd)
                U_POSX_Z: pos_x_reg <= sat32(48'(pos_x_reg) + 48'(qold_reg) - 48'(div_q));
                U_POSY_Z: pos_y_reg <= sat32(48'(pos_y_reg) + 48'(qold_reg) - 48'(div_q));
                U_RATE: begin
                    rate_reg  <= sat24(48'(rate_reg) - f16);
                    scale_reg <= snew_reg;
                end
                U_POSX_P: pos_x_reg <= sat32(48'(pos_x_reg) + f16);
                U_POSY_P: pos_y_reg <= sat32(48'(pos_y_reg) + f16);
                U_VELX:   vel_x_reg <= sat32(48'(vel_x_reg) - f16);
                U_VELY:   vel_y_reg <= sat32(48'(vel_y_reg) - f16);
                default: ;
            endcase
        end
    end

    assign status.is_tick  = (act_reg == ACT_TICK);
    assign status.zoom_go  = (rate_reg > ZoomRunLimit) || (rate_reg < -ZoomRunLimit);
    assign status.pan_go   = !drag_reg && (sq_sum > SpeedSqLimit);
    assign status.div_done = div_done;
    assign m_tdata = out_reg;

endmodule

// File: src/pan_zoom_inertia_step.sv
// ----------------------------------------------------------------------------
// pan_zoom_inertia_step
// 2D view camera with inertial zoom and pan, one result per request.
// A zooming tick runs four passes of the shared divider (46 quotient bits each)
// plus the steps of the shared multiplier; impulse and velocity requests use
// neither. One request in flight at a time.
// Reset (aresetn, synchronous): camera state and registers to defaults.
// ----------------------------------------------------------------------------
module pan_zoom_inertia_step
    import pzi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // time_step, dragging, zoom_impulse, pivot_x, pivot_y,
    // new_velocity_x, new_velocity_y
    input  logic [InDataW-1:0]  s_tdata,
    input  logic [1:0]          s_tuser,  // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata   // position_x, position_y, zoom_scale
);

    cmd_t    cmd;
    status_t status;

    pzi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pzi_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

// File: tb/sv/pan_zoom_inertia_step_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pan_zoom_inertia_step_test
// Self-checking bench for the pan/zoom camera. Requests go in on the s_ stream
// and are mirrored by a camera predictor in the bench. Each view on the m_
// stream is checked field by field against the oldest predicted view. Ready
// and valid idle at random. One long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module pan_zoom_inertia_step_test;
    import pzi_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WatchdogLimit = 20000;
    localparam int HoldOffCycles = 400;

    typedef struct packed {
        logic [23:0]        sc;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } view_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [CfgW-1:0]     cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    pan_zoom_inertia_step dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // camera mirror
    longint cam_x, cam_y, cam_scale, cam_rate, cam_vx, cam_vy, cam_pvx, cam_pvy;
    longint lim_min, lim_max, fric_zoom, fric_drag, win_w, win_h;

    view_t  view_q[$];
    int     errors = 0;
    int     requests = 0;
    int     views = 0;
    bit     steady = 0;
    int     hold_req = 0;
    int     hold_seen = 0;
    int     rx_wait = 0;
    int     idle_cycles = 0;

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint clip32(longint x);
        return clip(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint pivot_shift(longint d, longint s_old, longint s_new);
        longint n;
        n = d * (longint'(1) <<< 31);
        return n / s_old - n / s_new;
    endfunction

    function automatic view_t advance_camera(logic [1:0] act, logic [15:0] dt_in,
                                             logic drag, logic [23:0] imp,
                                             logic [12:0] pvx, logic [12:0] pvy,
                                             logic [31:0] vx, logic [31:0] vy);
        longint dt, s_old, s_new, k;
        longint unsigned ax, ay;
        view_t v;
        dt = longint'(dt_in);
        if (act == ACT_IMPULSE) begin
            cam_rate = clip(cam_rate + longint'($signed(imp)), -8388608, 8388607);
            cam_pvx = longint'(pvx);
            cam_pvy = longint'(pvy);
        end else if (act == ACT_VELOCITY) begin
            cam_vx = longint'($signed(vx));
            cam_vy = longint'($signed(vy));
        end else if (act == ACT_TICK) begin
            if (cam_rate > 32768 || cam_rate < -32768) begin
                s_old = cam_scale;
                s_new = s_old + ((cam_rate * dt) >>> 16);
                if (s_new < lim_min) s_new = lim_min;
                if (s_new > lim_max) s_new = lim_max;
                if (s_new < 1) s_new = 1;
                cam_x = clip32(cam_x + pivot_shift(2 * cam_pvx - win_w, s_old, s_new));
                cam_y = clip32(cam_y + pivot_shift(2 * cam_pvy - win_h, s_old, s_new));
                cam_scale = s_new;
                k = (dt * fric_zoom) >>> 16;
                cam_rate = clip(cam_rate - ((cam_rate * k) >>> 16), -8388608, 8388607);
            end
            if (!drag) begin
                ax = longint'(cam_vx < 0 ? -cam_vx : cam_vx);
                ay = longint'(cam_vy < 0 ? -cam_vy : cam_vy);
                if (ax * ax + ay * ay > (64'd225 << 32)) begin
                    k = (dt * fric_drag) >>> 16;
                    cam_x = clip32(cam_x + ((cam_vx * dt) >>> 16));
                    cam_y = clip32(cam_y + ((cam_vy * dt) >>> 16));
                    cam_vx = clip32(cam_vx - ((cam_vx * k) >>> 16));
                    cam_vy = clip32(cam_vy - ((cam_vy * k) >>> 16));
                end
            end
        end
        v.px = cam_x[31:0];
        v.py = cam_y[31:0];
        v.sc = cam_scale[23:0];
        return v;
    endfunction

    task automatic send_req(input logic [1:0] act, input logic [15:0] dt, input logic drag,
                            input logic [23:0] imp, input logic [12:0] pvx,
                            input logic [12:0] pvy, input logic [31:0] vx,
                            input logic [31:0] vy);
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, vy, vx, pvy, pvx, imp, drag, dt};
        do @(posedge aclk); while (!s_tready);
        view_q.push_back(advance_camera(act, dt, drag, imp, pvx, pvy, vx, vy));
        requests++;
    endtask

    task automatic send_random();
        logic [1:0]  act;
        logic [15:0] dt;
        logic [23:0] imp;
        logic [31:0] vx, vy;
        int          pick;
        pick = $urandom_range(0, 99);
        act = pick < 55 ? ACT_TICK : pick < 75 ? ACT_IMPULSE :
              pick < 95 ? ACT_VELOCITY : ACT_UNUSED;
        dt  = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
        imp = $urandom_range(0, 9) == 0 ? 24'($urandom) :
              24'($signed($urandom_range(0, 400000)) - 200000);
        vx  = $urandom_range(0, 9) == 0 ? $urandom :
              32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        vy  = $urandom_range(0, 9) == 0 ? $urandom :
              32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        send_req(act, dt, 1'($urandom_range(0, 3) == 0), imp, 13'($urandom),
                 13'($urandom), vx, vy);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (view_q.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CfgAddrW-1:0] idx, input longint val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CfgW-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MIN_SCALE:  lim_min   = val & 24'hFFFFFF;
            REG_MAX_SCALE:  lim_max   = val & 24'hFFFFFF;
            REG_SCALE_FRIC: fric_zoom = val & 24'hFFFFFF;
            REG_DRAG_FRIC:  fric_drag = val & 24'hFFFFFF;
            REG_WIN_W:      win_w     = val & 13'h1FFF;
            REG_WIN_H:      win_h     = val & 13'h1FFF;
            default: ;
        endcase
    endtask

    task automatic set_all(input longint mn, input longint mx, input longint fz,
                           input longint fd, input longint w, input longint h);
        set_reg(REG_MIN_SCALE, mn);
        set_reg(REG_MAX_SCALE, mx);
        set_reg(REG_SCALE_FRIC, fz);
        set_reg(REG_DRAG_FRIC, fd);
        set_reg(REG_WIN_W, w);
        set_reg(REG_WIN_H, h);
    endtask

    task automatic test_directed();
        send_req(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'h7FFFFF, 13'h1FFF, 13'h0000, '0, '0);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'h7FFFFF, 13'h1FFF, 13'h1FFF, '0, '0);
        send_req(ACT_TICK, 16'h1000, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_TICK, 16'hFFFF, 1'b1, '0, '0, '0, '0, '0);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'h800000, 13'h0000, 13'h1FFF, '0, '0);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'h800000, 13'h0000, 13'h0000, '0, '0);
        send_req(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_TICK, 16'h0001, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_VELOCITY, '0, 1'b0, '0, '0, '0, 32'h7FFFFFFF, 32'h80000000);
        send_req(ACT_TICK, 16'hFFFF, 1'b1, '0, '0, '0, '0, '0);
        send_req(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_VELOCITY, '0, 1'b0, '0, '0, '0, 32'd983040, 32'd0);
        send_req(ACT_TICK, 16'h8000, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_VELOCITY, '0, 1'b0, '0, '0, '0, 32'd983041, 32'hFFFF0000);
        send_req(ACT_TICK, 16'h8000, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_UNUSED, 16'hFFFF, 1'b1, 24'hFFFFFF, 13'h1FFF, 13'h1FFF,
                 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'd32769, 13'd960, 13'd540, '0, '0);
        send_req(ACT_TICK, 16'h4000, 1'b0, '0, '0, '0, '0, '0);
        drain();
    endtask

    task automatic test_register_extremes();
        // crossed limits, zero and full friction, smallest and largest window
        set_all(24'hFFFFFF, 1, 0, 24'hFFFFFF, 1, 8191);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'h200000, 13'd5, 13'd4000, '0, '0);
        send_req(ACT_TICK, 16'h2000, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_VELOCITY, '0, 1'b0, '0, '0, '0, 32'h01000000, 32'hFF000000);
        send_req(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);
        drain();
        set_all(1, 24'hFFFFFF, 24'hFFFFFF, 0, 8191, 1);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'h800000, 13'd8191, 13'd0, '0, '0);
        repeat (4) send_req(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);
        send_req(ACT_IMPULSE, '0, 1'b0, 24'h7FFFFF, 13'd1, 13'd8190, '0, '0);
        repeat (4) send_req(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 4; ph++) begin
            set_all($urandom_range(1, 70000), $urandom_range(60000, 2000000),
                    $urandom_range(0, 600000), $urandom_range(0, 600000),
                    $urandom_range(1, 8191), $urandom_range(1, 8191));
            if (ph == 3) steady = 1;
            repeat (380) send_random();
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        repeat (10) send_random();
        drain();
    endtask

    // result side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            rx_wait = HoldOffCycles;
        end
        if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else if (!steady && aresetn && $urandom_range(0, 7) == 0) begin
            rx_wait = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        view_t exp_v, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            views++;
            if (view_q.size() == 0) begin
                $display("%0t: unexpected view px=%h py=%h sc=%h", $time,
                         got.px, got.py, got.sc);
                errors++;
            end else begin
                exp_v = view_q.pop_front();
                if (got.px !== exp_v.px) begin
                    $display("%0t: position_x expected %h got %h", $time, exp_v.px, got.px);
                    errors++;
                end
                if (got.py !== exp_v.py) begin
                    $display("%0t: position_y expected %h got %h", $time, exp_v.py, got.py);
                    errors++;
                end
                if (got.sc !== exp_v.sc) begin
                    $display("%0t: zoom_scale expected %h got %h", $time, exp_v.sc, got.sc);
                    errors++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        cam_x = 0; cam_y = 0; cam_scale = 65536; cam_rate = 0;
        cam_vx = 0; cam_vy = 0; cam_pvx = 0; cam_pvy = 0;
        lim_min = 6554; lim_max = 655360; fric_zoom = 262144; fric_drag = 393216;
        win_w = 1920; win_h = 1080;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_register_extremes();
        test_random_phases();
        repeat (20) @(posedge aclk);
        $display("Ran %0d requests, %0d views checked: directed extremes, register", requests,
                 views);
        $display("extremes, receiver hold-off and four random register settings.");
        if (errors == 0 && view_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/pzi_pkg.sv
src/pzi_div.sv
src/pzi_ctrl.sv
src/pzi_dp.sv
src/pan_zoom_inertia_step.sv
tb/sv/pan_zoom_inertia_step_test.sv
